// ----- hw/rtl/wsa_pkg.sv -----
// Shared constants for the wall sensor analyser: config register indexes.
package wsa_pkg;

	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SIDE_REF_LEFT   = 3'd0;
	localparam cfg_idx_t REG_SIDE_REF_RIGHT  = 3'd1;
	localparam cfg_idx_t REG_ANGLE_REF_LEFT  = 3'd2;
	localparam cfg_idx_t REG_ANGLE_REF_RIGHT = 3'd3;
	localparam cfg_idx_t REG_EXIST_THRESH    = 3'd4;
	localparam cfg_idx_t REG_STEP_DISABLE    = 3'd5;
	localparam cfg_idx_t REG_EDGE_DROP       = 3'd6;
	localparam cfg_idx_t REG_CENTER_CLIP     = 3'd7;

endpackage

// ----- hw/rtl/wsa_if.sv -----
// Valid/ready channel interfaces: sensor samples, analysis results, config writes.
interface wsa_sample_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sensor_left;
	logic [SAMPLE_BITS-1:0] sensor_right;
	logic [SAMPLE_BITS-1:0] sensor_front;

	modport source (output valid, sensor_left, sensor_right, sensor_front, input ready);
	modport sink   (input valid, sensor_left, sensor_right, sensor_front, output ready);
endinterface

interface wsa_result_if #(parameter int SAMPLE_BITS = 12);
	logic                          valid;
	logic                          ready;
	logic                          wall_left;
	logic                          wall_right;
	logic                          wall_front;
	logic                          edge_left;
	logic                          edge_right;
	logic signed [SAMPLE_BITS:0]   lateral_offset;
	logic signed [SAMPLE_BITS+1:0] front_distance;
	logic signed [SAMPLE_BITS+1:0] heading_angle;

	modport source (output valid, wall_left, wall_right, wall_front, edge_left, edge_right,
		lateral_offset, front_distance, heading_angle, input ready);
	modport sink   (input valid, wall_left, wall_right, wall_front, edge_left, edge_right,
		lateral_offset, front_distance, heading_angle, output ready);
endinterface

interface wsa_cfg_if #(parameter int SAMPLE_BITS = 12);
	import wsa_pkg::*;
	logic                     valid;
	logic                     ready;
	cfg_idx_t                 index;
	logic [3*SAMPLE_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/wsa_cell.sv -----
// One offset history cell: holds an entry, flags zero, passes it on when the chain shifts.
module wsa_cell #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift_en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q,
	output logic         q_zero
);
	import wsa_pkg::*;

	logic [W-1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q      = entry_q;
	assign q_zero = (entry_q == '0);

endmodule

// ----- hw/rtl/wall_sensor_analyser_unit.sv -----
// Wall sensor analyser top level: side/front wall flags, edges, offset history chain.
//
//  channel  | dir | carries
//  ---------+-----+------------------------------------------------------------
//  samples  | in  | sensor_left, sensor_right, sensor_front
//  result   | out | wall/edge flags, lateral_offset, front_distance, heading_angle
//  cfg      | in  | index, data (always ready)
//
// Two register stages; one request per cycle sustained while the result is not stalled.
// Stage 1 forms deviations and flags, stage 2 clips and scans the history cell chain.
// Reset clears config to defaults, previous samples and every history cell.
// A stalled result holds the output register; stage 1 still fills behind it.
module wall_sensor_analyser_unit #(
	parameter int HISTORY_DEPTH = 4,
	parameter int SAMPLE_BITS   = 12
) (
	input logic         clk,
	input logic         arst_n,
	wsa_sample_if.sink  samples,
	wsa_result_if.source result,
	wsa_cfg_if.sink     cfg
);
	import wsa_pkg::*;

	localparam int N     = SAMPLE_BITS;
	localparam int NCELL = HISTORY_DEPTH - 1;

	// config
	logic [N-1:0]   side_ref_left_q, side_ref_right_q;
	logic [N-1:0]   angle_ref_left_q, angle_ref_right_q;
	logic [3*N-1:0] exist_q;
	logic [N-1:0]   step_q, drop_q, clip_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_ref_left_q   <= '0;
			side_ref_right_q  <= '0;
			angle_ref_left_q  <= '0;
			angle_ref_right_q <= '0;
			exist_q           <= '0;
			step_q            <= '1;
			drop_q            <= '1;
			clip_q            <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SIDE_REF_LEFT:   side_ref_left_q   <= cfg.data[N-1:0];
				REG_SIDE_REF_RIGHT:  side_ref_right_q  <= cfg.data[N-1:0];
				REG_ANGLE_REF_LEFT:  angle_ref_left_q  <= cfg.data[N-1:0];
				REG_ANGLE_REF_RIGHT: angle_ref_right_q <= cfg.data[N-1:0];
				REG_EXIST_THRESH:    exist_q           <= cfg.data;
				REG_STEP_DISABLE:    step_q            <= cfg.data[N-1:0];
				REG_EDGE_DROP:       drop_q            <= cfg.data[N-1:0];
				REG_CENTER_CLIP:     clip_q            <= cfg.data[N-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic v_s1, v_s2, adv2, accept;

	assign adv2          = v_s1 && (!v_s2 || result.ready);
	assign samples.ready = !v_s1 || adv2;
	assign accept        = samples.valid && samples.ready;
	assign result.valid  = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// stage 1
	logic [N-1:0] last_left_q, last_right_q;
	logic [N-1:0] l, r, f, thr_l, thr_r, thr_f;
	logic [N-1:0] jd_l, jd_r;
	logic         wl, wr, wf, el, er;
	logic signed [N:0]   dev_l, dev_r, al, ar;
	logic signed [N+1:0] front, angle;

	assign l     = samples.sensor_left;
	assign r     = samples.sensor_right;
	assign f     = samples.sensor_front;
	assign thr_l = exist_q[N-1:0];
	assign thr_r = exist_q[2*N-1:N];
	assign thr_f = exist_q[3*N-1:2*N];

	always_comb begin
		jd_l  = (l > last_left_q) ? (l - last_left_q) : (last_left_q - l);
		jd_r  = (r > last_right_q) ? (r - last_right_q) : (last_right_q - r);
		wl    = l > thr_l;
		wr    = r > thr_r;
		wf    = f > thr_f;
		el    = !wl && (last_left_q > thr_l) && (last_left_q > l)
			&& ((last_left_q - l) > drop_q);
		er    = !wr && (last_right_q > thr_r) && (last_right_q > r)
			&& ((last_right_q - r) > drop_q);
		dev_l = $signed({1'b0, l}) - $signed({1'b0, side_ref_left_q});
		dev_r = $signed({1'b0, r}) - $signed({1'b0, side_ref_right_q});
		if (!wl || (jd_l > step_q)) begin
			dev_l = '0;
		end
		if (!wr || (jd_r > step_q)) begin
			dev_r = '0;
		end
		al    = $signed({1'b0, l}) - $signed({1'b0, angle_ref_left_q});
		ar    = $signed({1'b0, r}) - $signed({1'b0, angle_ref_right_q});
		front = $signed({al[N], al}) + $signed({ar[N], ar});
		angle = $signed({al[N], al}) - $signed({ar[N], ar});
	end

	logic                wl_s1, wr_s1, wf_s1, el_s1, er_s1;
	logic signed [N:0]   dev_l_s1, dev_r_s1;
	logic signed [N+1:0] front_s1, angle_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (accept) begin
			last_left_q  <= l;
			last_right_q <= r;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wl_s1    <= wl;
			wr_s1    <= wr;
			wf_s1    <= wf;
			el_s1    <= el;
			er_s1    <= er;
			dev_l_s1 <= dev_l;
			dev_r_s1 <= dev_r;
			front_s1 <= front;
			angle_s1 <= angle;
		end
	end

	// stage 2: clip, history chain
	logic signed [N+1:0] off, lim, off_clip;
	logic signed [N:0]   off_new;
	logic [N:0]          cell_d [NCELL+1];
	logic [NCELL-1:0]    cell_zero;
	logic                any_zero;

	always_comb begin
		off = $signed({dev_l_s1[N], dev_l_s1}) - $signed({dev_r_s1[N], dev_r_s1});
		lim = $signed({2'b00, clip_q});
		if (off > lim) begin
			off_clip = lim;
		end else if (off < -lim) begin
			off_clip = -lim;
		end else begin
			off_clip = off;
		end
		off_new  = off_clip[N:0];
		any_zero = (off_new == '0) || (|cell_zero);
	end

	assign cell_d[0] = off_new;

	genvar gi;
	generate
		for (gi = 0; gi < NCELL; gi++) begin : g_cell
			wsa_cell #(
				.W(N + 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(adv2),
				.d       (cell_d[gi]),
				.q       (cell_d[gi+1]),
				.q_zero  (cell_zero[gi])
			);
		end
	endgenerate

	logic                wl_s2, wr_s2, wf_s2, el_s2, er_s2;
	logic signed [N:0]   lat_s2;
	logic signed [N+1:0] front_s2, angle_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			wl_s2    <= wl_s1;
			wr_s2    <= wr_s1;
			wf_s2    <= wf_s1;
			el_s2    <= el_s1;
			er_s2    <= er_s1;
			lat_s2   <= any_zero ? '0 : off_new;
			front_s2 <= front_s1;
			angle_s2 <= angle_s1;
		end
	end

	assign result.wall_left      = wl_s2;
	assign result.wall_right     = wr_s2;
	assign result.wall_front     = wf_s2;
	assign result.edge_left      = el_s2;
	assign result.edge_right     = er_s2;
	assign result.lateral_offset = lat_s2;
	assign result.front_distance = front_s2;
	assign result.heading_angle  = angle_s2;

endmodule
